// File: rtl/sha224_pkg.sv
package sha224_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned DigestWords = 7;
   localparam int unsigned CountWidth  = 61;
   localparam int unsigned LenBytePos  = 56;
   localparam logic [7:0]  PadMarker   = 8'h80;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINISH,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load_init;
      logic       write_byte;
      logic [7:0] write_data;
      logic       count_inc;
      logic       pad_write;
      logic       pad_len;
      logic       start_comp;
      logic       round_step;
      logic       finish_comp;
      logic       clear_count;
   } cmd_type;

   typedef struct packed {
      logic       block_full;
      logic       rounds_done;
      logic       pad_done;
      logic       pad_wraps;
   } status_type;

   function automatic word_type kround(input logic [5:0] t);
      word_type k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      return k[t];
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h [0:7];
      h = '{
         32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
         32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
      };
      return h[i];
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

// File: rtl/sha224_if.sv
interface sha224_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha224_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/sha224_datapath.sv
module sha224_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha224_pkg::cmd_type    cmd,
   output sha224_pkg::status_type status,
   input  logic [2:0]             rd_index,
   output sha224_pkg::word_type   rd_word
);
   import sha224_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [5:0]            pad_pos_ff, pad_pos_in;
   logic [6:0]            round_ff, round_in;
   word_type              hash_ff [0:7];
   word_type              var_ff [0:7];
   word_type              win_ff [0:BlockWords-1];
   logic [63:0]           bit_len;
   logic [5:0]            pos;
   logic [5:0]            t;
   word_type              w, x2, x15, s0, s1, t1, t2;
   logic [7:0]            pad_byte;

   assign bit_len = {count_ff, 3'b000};
   assign pos     = count_ff[5:0];
   assign t       = round_ff[5:0];

   // length bytes sit at 56..63, most significant first
   always_comb begin
      if (cmd.pad_len && pad_pos_ff[5:3] == 3'b111)
         pad_byte = bit_len[{~pad_pos_ff[2:0], 3'b000} +: 8];
      else
         pad_byte = 8'h00;
   end

   always_comb begin
      count_in   = count_ff;
      pad_pos_in = pad_pos_ff;
      if (cmd.clear_count)
         count_in = '0;
      else if (cmd.count_inc)
         count_in = count_ff + 1'b1;
      if (cmd.write_byte && !cmd.count_inc)
         pad_pos_in = pos + 1'b1;
      else if (cmd.pad_write)
         pad_pos_in = pad_pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pad_pos_ff <= '0;
      end else begin
         count_ff   <= count_in;
         pad_pos_ff <= pad_pos_in;
      end
   end

   always_comb begin
      x2  = win_ff[4'(t - 6'd2)];
      x15 = win_ff[4'(t - 6'd15)];
      s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
      s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
      if (round_ff < 7'd16)
         w = win_ff[t[3:0]];
      else
         w = s1 + win_ff[4'(t - 6'd7)] + s0 + win_ff[t[3:0]];
      t1 = var_ff[7] + (rotr(var_ff[4], 6) ^ rotr(var_ff[4], 11) ^ rotr(var_ff[4], 25))
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6])) + kround(t) + w;
      t2 = (rotr(var_ff[0], 2) ^ rotr(var_ff[0], 13) ^ rotr(var_ff[0], 22))
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // block bytes land directly in the schedule window, big-endian within a word
   always_comb begin
      round_in = round_ff;
      if (cmd.start_comp)
         round_in = '0;
      else if (cmd.round_step)
         round_in = round_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         round_ff <= '0;
      else
         round_ff <= round_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         win_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= cmd.write_data;
      end else if (cmd.pad_write) begin
         win_ff[pad_pos_ff[5:2]][{~pad_pos_ff[1:0], 3'b000} +: 8] <= pad_byte;
      end else if (cmd.start_comp) begin
         for (int i = 0; i < 8; i++)
            var_ff[i] <= hash_ff[i];
      end else if (cmd.round_step) begin
         win_ff[t[3:0]] <= w;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_init) begin
         for (int i = 0; i < 8; i++)
            hash_ff[i] <= init_hash(3'(i));
      end else if (cmd.finish_comp) begin
         for (int i = 0; i < 8; i++)
            hash_ff[i] <= hash_ff[i] + var_ff[i];
      end
   end

   assign rd_word            = hash_ff[rd_index];
   assign status.block_full  = (pos == 6'd63);
   assign status.rounds_done = (round_ff == 7'(Rounds));
   assign status.pad_done    = (pad_pos_ff == 6'(BlockBytes - 1));
   assign status.pad_wraps   = (pos > 6'(LenBytePos - 1));
endmodule

// File: rtl/sha224_ctrl.sv
module sha224_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   sha224_req_if.sink             req,
   sha224_rsp_if.source           rsp,
   output sha224_pkg::cmd_type    cmd,
   input  sha224_pkg::status_type status,
   output logic [2:0]             rd_index,
   input  sha224_pkg::word_type   rd_word
);
   import sha224_pkg::*;

   state_type  state_ff, state_in;
   logic       fin_ff, fin_in;      // message close pending
   logic       last_ff, last_in;    // current compression is the final one
   logic       len_ff, len_in;      // padding pass carries the bit length
   logic [2:0] idx_ff, idx_in;
   logic       acc;

   assign acc      = req.valid && req.ready;
   assign rd_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               fin_in  = req.end_of_message;
               last_in = 1'b0;
               len_in  = 1'b0;
               if (req.has_byte && status.block_full)
                  state_in = ST_LOAD;
               else if (req.end_of_message)
                  state_in = ST_FINISH;
            end
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (status.rounds_done) begin
               if (last_ff) begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else if (fin_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            if (len_ff) begin
               state_in = ST_PAD;
            end else begin
               // if the marker fills the block: compress it, then an all-padding block; else pad it
               len_in = !status.pad_wraps || status.block_full;
               if (status.block_full)
                  state_in = ST_LOAD;
               else
                  state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (status.pad_done) begin
               state_in = ST_LOAD;
               if (len_ff)
                  last_in = 1'b1;
               else
                  len_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'(DigestWords - 1)) begin
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.write_data = PadMarker;
      req.ready      = 1'b0;
      rsp.valid      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (acc && req.has_byte) begin
               cmd.write_byte = 1'b1;
               cmd.count_inc  = 1'b1;
               cmd.write_data = req.data_byte;
            end
         end
         ST_LOAD:  cmd.start_comp = 1'b1;
         ST_ROUND: begin
            if (status.rounds_done)
               cmd.finish_comp = 1'b1;
            else
               cmd.round_step = 1'b1;
         end
         ST_FINISH: begin
            if (!len_ff)
               cmd.write_byte = 1'b1;
         end
         ST_PAD: begin
            cmd.pad_write = 1'b1;
            cmd.pad_len   = len_ff;
         end
         ST_EMIT: begin
            rsp.valid = 1'b1;
            if (rsp.ready && idx_ff == 3'(DigestWords - 1)) begin
               cmd.load_init   = 1'b1;
               cmd.clear_count = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp.digest_word = rd_word;
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'(DigestWords - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         len_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
      end
   end
endmodule

// File: rtl/sha224_byte_stream_hasher_top.sv
// SHA-224 hasher fed one message byte per req item; end_of_message (with or without a byte)
// closes the message and seven rsp items carry the digest, word 0 first. The byte that
// fills the 64-byte block also starts its compression: a load step, the 64 rounds and the
// final adds, during which req_ready is low and no further byte is taken. Closing writes
// the 0x80 marker, fills the rest of the block one byte a cycle (zeros, then the bit length
// from byte 56) and compresses it; with fewer than nine bytes free after the last message
// byte, a second all-padding block follows. After the close, req_ready stays low until the
// seventh rsp item is taken; each rsp item holds until rsp_ready, and the chaining value
// then returns to the initial hash for the next message.
module sha224_byte_stream_hasher_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_has_byte,
   input  logic         req_end_of_message,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_digest_word,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last_word
);
   import sha224_pkg::*;

   sha224_req_if req ();
   sha224_rsp_if rsp ();
   cmd_type      cmd;
   status_type   status;
   logic [2:0]   rd_index;
   word_type     rd_word;

   assign req.valid          = req_valid;
   assign req.data_byte      = req_data_byte;
   assign req.has_byte       = req_has_byte;
   assign req.end_of_message = req_end_of_message;
   assign req_ready          = req.ready;
   assign rsp_valid          = rsp.valid;
   assign rsp.ready          = rsp_ready;
   assign rsp_digest_word    = rsp.digest_word;
   assign rsp_word_index     = rsp.word_index;
   assign rsp_last_word      = rsp.last_word;

   sha224_ctrl u_ctrl (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .cmd, .status, .rd_index, .rd_word
   );

   sha224_datapath u_dp (
      .clock, .reset, .cmd, .status, .rd_index, .rd_word
   );
endmodule
